// ===== hw/rtl/owbm_pkg.sv =====
// Package for the single-wire bus master: command and register codes,
// register widths and reset values, and the structs shared between modules.
// No dependencies.
package owbm_pkg;

    localparam int TIMER_BITS_DEFAULT = 10;

    localparam int CFG_DATA_W  = 10;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_RESET = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RESET_LOW     = 3'd0,
        REG_RESET_RELEASE = 3'd1,
        REG_PRESENCE_WAIT = 3'd2,
        REG_SHORT_LOW     = 3'd3,
        REG_LONG_SLOT     = 3'd4,
        REG_READ_SAMPLE   = 3'd5,
        REG_READ_RECOVER  = 3'd6
    } reg_index_t;

    localparam logic [9:0] RESET_LOW_INIT     = 10'd750;
    localparam logic [7:0] RESET_RELEASE_INIT = 8'd20;
    localparam logic [9:0] PRESENCE_WAIT_INIT = 10'd200;
    localparam logic [3:0] SHORT_LOW_INIT     = 4'd2;
    localparam logic [6:0] LONG_SLOT_INIT     = 7'd60;
    localparam logic [3:0] READ_SAMPLE_INIT   = 4'd12;
    localparam logic [7:0] READ_RECOVER_INIT  = 8'd50;

    typedef struct packed {
        logic [9:0] reset_low_time;
        logic [7:0] reset_release_time;
        logic [9:0] presence_wait_limit;
        logic [3:0] short_low_time;
        logic [6:0] long_slot_time;
        logic [3:0] read_sample_delay;
        logic [7:0] read_recover_time;
    } cfg_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       status;
        logic [7:0] rx_byte;
    } res_t;

endpackage

// ===== hw/rtl/owbm_cfg.sv =====
// Timing register file of the single-wire bus master.
// Depends on owbm_pkg.
module owbm_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [owbm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [owbm_pkg::CFG_DATA_W-1:0]   cfg_data,
    output owbm_pkg::cfg_t                    cfg
);

    owbm_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_time      <= owbm_pkg::RESET_LOW_INIT;
            cfg_reg.reset_release_time  <= owbm_pkg::RESET_RELEASE_INIT;
            cfg_reg.presence_wait_limit <= owbm_pkg::PRESENCE_WAIT_INIT;
            cfg_reg.short_low_time      <= owbm_pkg::SHORT_LOW_INIT;
            cfg_reg.long_slot_time      <= owbm_pkg::LONG_SLOT_INIT;
            cfg_reg.read_sample_delay   <= owbm_pkg::READ_SAMPLE_INIT;
            cfg_reg.read_recover_time   <= owbm_pkg::READ_RECOVER_INIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                owbm_pkg::REG_RESET_LOW:
                    cfg_reg.reset_low_time <= cfg_data[9:0];
                owbm_pkg::REG_RESET_RELEASE:
                    cfg_reg.reset_release_time <= cfg_data[7:0];
                owbm_pkg::REG_PRESENCE_WAIT:
                    cfg_reg.presence_wait_limit <= cfg_data[9:0];
                owbm_pkg::REG_SHORT_LOW:
                    cfg_reg.short_low_time <= cfg_data[3:0];
                owbm_pkg::REG_LONG_SLOT:
                    cfg_reg.long_slot_time <= cfg_data[6:0];
                owbm_pkg::REG_READ_SAMPLE:
                    cfg_reg.read_sample_delay <= cfg_data[3:0];
                owbm_pkg::REG_READ_RECOVER:
                    cfg_reg.read_recover_time <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/owbm_step.sv =====
// Slot sequencer of the single-wire bus master: phase, timer, bit counter and
// shift register, advanced by one tick per accepted beat. Depends on owbm_pkg.
module owbm_step
#(
    parameter int TIMER_BITS = owbm_pkg::TIMER_BITS_DEFAULT
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step_en,
    input  logic [1:0]      cmd,
    input  logic [7:0]      tx_byte,
    input  logic            bus_level,
    input  owbm_pkg::cfg_t  cfg,
    output owbm_pkg::res_t  res
);

    localparam int CMP_W = (TIMER_BITS + 1 > owbm_pkg::CFG_DATA_W) ?
                           TIMER_BITS + 1 : owbm_pkg::CFG_DATA_W;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_REL,
        PH_PRES_LOW,
        PH_PRES_HIGH,
        PH_WR_LOW,
        PH_WR_HIGH,
        PH_RD_LOW,
        PH_RD_REL,
        PH_RD_REC
    } phase_t;

    phase_t                  phase_reg, phase_next, phase_cur;
    logic [TIMER_BITS-1:0]   tick_reg, tick_next, tick_cur;
    logic [2:0]              bit_reg, bit_next, bit_cur;
    logic [7:0]              shift_reg, shift_next, shift_cur;
    logic                    pres_reg, pres_next;
    logic [7:0]              rd_reg, rd_next;

    logic                         start;
    logic [owbm_pkg::CFG_DATA_W-1:0] dur;
    logic [CMP_W-1:0]             inc_w;
    logic [CMP_W-1:0]             dur_w;
    logic [CMP_W-1:0]             tmax_w;
    logic                         over;
    logic [TIMER_BITS-1:0]        tick_adv;
    logic                         drive;
    logic                         done;

    always_comb
    begin
        start     = (phase_reg == PH_IDLE) && (cmd != owbm_pkg::CMD_TICK);
        phase_cur = phase_reg;
        tick_cur  = tick_reg;
        bit_cur   = bit_reg;
        shift_cur = shift_reg;
        if (start)
        begin
            tick_cur = '0;
            bit_cur  = '0;
            case (cmd)
                owbm_pkg::CMD_RESET:
                    phase_cur = PH_RST_LOW;
                owbm_pkg::CMD_WRITE:
                begin
                    phase_cur = PH_WR_LOW;
                    shift_cur = tx_byte;
                end
                default:
                begin
                    phase_cur = PH_RD_LOW;
                    shift_cur = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        case (phase_cur)
            PH_RST_LOW:   dur = cfg.reset_low_time;
            PH_RST_REL:   dur = 10'(cfg.reset_release_time);
            PH_PRES_LOW,
            PH_PRES_HIGH: dur = cfg.presence_wait_limit;
            PH_WR_LOW:    dur = shift_cur[0] ? 10'(cfg.short_low_time)
                                             : 10'(cfg.long_slot_time);
            PH_WR_HIGH:   dur = shift_cur[0] ? 10'(cfg.long_slot_time)
                                             : 10'(cfg.short_low_time);
            PH_RD_LOW:    dur = 10'(cfg.short_low_time);
            PH_RD_REL:    dur = 10'(cfg.read_sample_delay);
            PH_RD_REC:    dur = 10'(cfg.read_recover_time);
            default:      dur = '0;
        endcase
        inc_w    = CMP_W'(tick_cur) + CMP_W'(1);
        dur_w    = CMP_W'(dur);
        tmax_w   = CMP_W'({TIMER_BITS{1'b1}});
        over     = (inc_w >= dur_w) || (inc_w >= tmax_w);
        tick_adv = over ? '0 : inc_w[TIMER_BITS-1:0];
    end

    always_comb
    begin
        phase_next = phase_cur;
        tick_next  = tick_cur;
        bit_next   = bit_cur;
        shift_next = shift_cur;
        pres_next  = pres_reg;
        rd_next    = rd_reg;
        drive      = 1'b0;
        done       = 1'b0;
        case (phase_cur)
            PH_RST_LOW:
            begin
                drive     = 1'b1;
                tick_next = tick_adv;
                if (over)
                begin
                    phase_next = PH_RST_REL;
                end
            end
            PH_RST_REL:
            begin
                tick_next = tick_adv;
                if (over)
                begin
                    phase_next = PH_PRES_LOW;
                end
            end
            PH_PRES_LOW:
            begin
                if (!bus_level)
                begin
                    tick_next  = '0;
                    phase_next = PH_PRES_HIGH;
                end
                else
                begin
                    tick_next = tick_adv;
                    if (over)
                    begin
                        pres_next  = 1'b1;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                end
            end
            PH_PRES_HIGH:
            begin
                if (bus_level)
                begin
                    tick_next  = '0;
                    pres_next  = 1'b0;
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
                else
                begin
                    tick_next = tick_adv;
                    if (over)
                    begin
                        pres_next  = 1'b1;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                end
            end
            PH_WR_LOW:
            begin
                drive     = 1'b1;
                tick_next = tick_adv;
                if (over)
                begin
                    phase_next = PH_WR_HIGH;
                end
            end
            PH_WR_HIGH:
            begin
                tick_next = tick_adv;
                if (over)
                begin
                    if (bit_cur == 3'd7)
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    else
                    begin
                        shift_next = {1'b0, shift_cur[7:1]};
                        bit_next   = bit_cur + 3'd1;
                        phase_next = PH_WR_LOW;
                    end
                end
            end
            PH_RD_LOW:
            begin
                drive     = 1'b1;
                tick_next = tick_adv;
                if (over)
                begin
                    phase_next = PH_RD_REL;
                end
            end
            PH_RD_REL:
            begin
                tick_next = tick_adv;
                if (over)
                begin
                    shift_next = {bus_level, shift_cur[7:1]};
                    phase_next = PH_RD_REC;
                end
            end
            PH_RD_REC:
            begin
                tick_next = tick_adv;
                if (over)
                begin
                    if (bit_cur == 3'd7)
                    begin
                        rd_next    = shift_cur;
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    else
                    begin
                        bit_next   = bit_cur + 3'd1;
                        phase_next = PH_RD_LOW;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            pres_reg  <= 1'b0;
            rd_reg    <= '0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            pres_reg  <= pres_next;
            rd_reg    <= rd_next;
        end
    end

    assign res.drive_low = drive;
    assign res.busy_res  = (phase_cur != PH_IDLE);
    assign res.done_res  = done;
    assign res.status    = pres_next;
    assign res.rx_byte   = rd_next;

endmodule

// ===== hw/rtl/one_wire_bus_master_unit.sv =====
// Top level of the single-wire bus master: input handshake, timing registers,
// slot sequencer and the output register. Depends on owbm_pkg, owbm_cfg and
// owbm_step.
//
// Each input beat is one 1 us tick: cmd, tx_byte and the sampled bus_level.
// A command other than tick-only starts a reset with presence detect, a byte
// write or a byte read when the master is idle; while busy it is ignored.
// Every accepted beat produces exactly one output beat carrying drive_low,
// busy_res, done_res, status and rx_byte.
// The result of a beat accepted at one edge is valid after that edge.
// Throughput is one beat per cycle while in_stall is low, set by the single
// registered pass through the slot sequencer.
// in_stall is raised only while a result is held and out_stall is high, so
// the sequencer and its timer advance only on accepted beats.
// Timing registers are written through cfg_we, cfg_index and cfg_data; the user
// must do so only while the master is idle; the block does not enforce it.
// Reset sets the defaults, idles the sequencer and empties the output register.
module one_wire_bus_master_unit
#(
    parameter int TIMER_BITS = owbm_pkg::TIMER_BITS_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [owbm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [owbm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        cmd,
    input  logic [7:0]                        tx_byte,
    input  logic                              bus_level,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              drive_low,
    output logic                              busy_res,
    output logic                              done_res,
    output logic                              status,
    output logic [7:0]                        rx_byte
);

    owbm_pkg::cfg_t cfg;
    owbm_pkg::res_t res;
    owbm_pkg::res_t res_reg;
    logic           out_valid_reg, out_valid_next;
    logic           accept;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    owbm_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    owbm_step
    #(
        .TIMER_BITS (TIMER_BITS)
    )
    u_step
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (accept),
        .cmd       (cmd),
        .tx_byte   (tx_byte),
        .bus_level (bus_level),
        .cfg       (cfg),
        .res       (res)
    );

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive_low = res_reg.drive_low;
    assign busy_res  = res_reg.busy_res;
    assign done_res  = res_reg.done_res;
    assign status    = res_reg.status;
    assign rx_byte   = res_reg.rx_byte;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for one_wire_bus_master_unit: timed bus commands with
// a simulated presence responder, random idling on both sides, per-tick checks.
// Depends on owbm_pkg and the RTL of the unit.
module tb;

    localparam int TIMER_MAX   = (1 << owbm_pkg::TIMER_BITS_DEFAULT) - 1;
    localparam int ITEM_TARGET = 2600;

    typedef logic [owbm_pkg::CFG_DATA_W-1:0] cfg_word_t;

    typedef enum int {
        SEQ_IDLE,
        SEQ_RST_LOW,
        SEQ_RST_REL,
        SEQ_PRES_LOW,
        SEQ_PRES_HIGH,
        SEQ_WR_LOW,
        SEQ_WR_HIGH,
        SEQ_RD_LOW,
        SEQ_RD_REL,
        SEQ_RD_REC
    } seq_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [owbm_pkg::CFG_INDEX_W-1:0] cfg_index = owbm_pkg::REG_RESET_LOW;
    logic [owbm_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    logic [1:0]                       cmd = owbm_pkg::CMD_TICK;
    logic [7:0]                       tx_byte = 8'h00;
    logic                             bus_level = 1'b1;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic                             drive_low;
    logic                             busy_res;
    logic                             done_res;
    logic                             status;
    logic [7:0]                       rx_byte;

    owbm_pkg::cfg_t timing;
    seq_t           seq;
    int             tcount;
    int             bit_pos;
    logic [7:0]     shift_reg;
    logic           no_presence;
    logic [7:0]     last_read;

    owbm_pkg::res_t expected_ticks[$];
    owbm_pkg::res_t want;

    int  pres_low_after;
    int  pres_high_after;
    bit  quiet_in;
    bit  quiet_out;
    int  beats_sent;
    int  mismatch_count;
    int  timing_sets;
    int  resets_run;
    int  writes_run;
    int  reads_run;
    int  devices_found;
    int  devices_missed;

    one_wire_bus_master_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .tx_byte   (tx_byte),
        .bus_level (bus_level),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .drive_low (drive_low),
        .busy_res  (busy_res),
        .done_res  (done_res),
        .status    (status),
        .rx_byte   (rx_byte)
    );

    always #5 clk = ~clk;

    function automatic bit slot_end(int dur);
        int nxt;
        nxt = tcount + 1;
        if (nxt >= dur || nxt >= TIMER_MAX)
        begin
            tcount = 0;
            return 1'b1;
        end
        tcount = nxt;
        return 1'b0;
    endfunction

    function automatic void end_presence(logic missed);
        no_presence = missed;
        seq = SEQ_IDLE;
        if (missed)
            devices_missed++;
        else
            devices_found++;
    endfunction

    function automatic owbm_pkg::res_t bus_master_tick(owbm_pkg::cmd_t c, logic [7:0] tx,
                                                       logic lvl);
        owbm_pkg::res_t r;
        logic cur;
        r = '0;
        if (seq == SEQ_IDLE && c != owbm_pkg::CMD_TICK)
        begin
            tcount = 0;
            bit_pos = 0;
            case (c)
                owbm_pkg::CMD_RESET:
                begin
                    seq = SEQ_RST_LOW;
                    resets_run++;
                end
                owbm_pkg::CMD_WRITE:
                begin
                    shift_reg = tx;
                    seq = SEQ_WR_LOW;
                    writes_run++;
                end
                default:
                begin
                    shift_reg = 8'h00;
                    seq = SEQ_RD_LOW;
                    reads_run++;
                end
            endcase
        end
        if (seq != SEQ_IDLE)
        begin
            r.busy_res = 1'b1;
            cur = shift_reg[0];
            case (seq)
                SEQ_RST_LOW:
                begin
                    r.drive_low = 1'b1;
                    if (slot_end(timing.reset_low_time))
                        seq = SEQ_RST_REL;
                end
                SEQ_RST_REL:
                    if (slot_end(timing.reset_release_time))
                        seq = SEQ_PRES_LOW;
                SEQ_PRES_LOW:
                    if (!lvl)
                    begin
                        tcount = 0;
                        seq = SEQ_PRES_HIGH;
                    end
                    else if (slot_end(timing.presence_wait_limit))
                    begin
                        end_presence(1'b1);
                        r.done_res = 1'b1;
                    end
                SEQ_PRES_HIGH:
                    if (lvl)
                    begin
                        tcount = 0;
                        end_presence(1'b0);
                        r.done_res = 1'b1;
                    end
                    else if (slot_end(timing.presence_wait_limit))
                    begin
                        end_presence(1'b1);
                        r.done_res = 1'b1;
                    end
                SEQ_WR_LOW:
                begin
                    r.drive_low = 1'b1;
                    if (slot_end(cur ? timing.short_low_time : timing.long_slot_time))
                        seq = SEQ_WR_HIGH;
                end
                SEQ_WR_HIGH:
                    if (slot_end(cur ? timing.long_slot_time : timing.short_low_time))
                    begin
                        if (bit_pos == 7)
                        begin
                            seq = SEQ_IDLE;
                            r.done_res = 1'b1;
                        end
                        else
                        begin
                            shift_reg = shift_reg >> 1;
                            bit_pos++;
                            seq = SEQ_WR_LOW;
                        end
                    end
                SEQ_RD_LOW:
                begin
                    r.drive_low = 1'b1;
                    if (slot_end(timing.short_low_time))
                        seq = SEQ_RD_REL;
                end
                SEQ_RD_REL:
                    if (slot_end(timing.read_sample_delay))
                    begin
                        shift_reg = {lvl, shift_reg[7:1]};
                        seq = SEQ_RD_REC;
                    end
                SEQ_RD_REC:
                    if (slot_end(timing.read_recover_time))
                    begin
                        if (bit_pos == 7)
                        begin
                            last_read = shift_reg;
                            seq = SEQ_IDLE;
                            r.done_res = 1'b1;
                        end
                        else
                        begin
                            bit_pos++;
                            seq = SEQ_RD_LOW;
                        end
                    end
                default:
                    ;
            endcase
        end
        r.status = no_presence;
        r.rx_byte = last_read;
        return r;
    endfunction

    // The simulated device answers the presence watch; elsewhere the line is noise,
    // which also supplies the bits of a byte read.
    function automatic logic line_level();
        case (seq)
            SEQ_PRES_LOW:  return tcount < pres_low_after;
            SEQ_PRES_HIGH: return tcount >= pres_high_after;
            default:       return 1'($urandom_range(0, 1));
        endcase
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= 30)
            $display("ERROR at %0t: %s", $time, what);
    endtask

    task automatic check_field(string name, int got, int exp_val);
        if (got != exp_val)
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, exp_val));
    endtask

    task automatic send_beat(owbm_pkg::cmd_t c, logic [7:0] tx, logic lvl);
        int gap;
        gap = quiet_in ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        tx_byte <= tx;
        bus_level <= lvl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_ticks.push_back(bus_master_tick(c, tx, lvl));
        beats_sent++;
    endtask

    task automatic run_command(owbm_pkg::cmd_t c, logic [7:0] tx);
        send_beat(c, tx, line_level());
        while (seq != SEQ_IDLE)
            send_beat(owbm_pkg::cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      line_level());
    endtask

    task automatic write_timing(owbm_pkg::reg_index_t idx, cfg_word_t val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            owbm_pkg::REG_RESET_LOW:     timing.reset_low_time = val[9:0];
            owbm_pkg::REG_RESET_RELEASE: timing.reset_release_time = val[7:0];
            owbm_pkg::REG_PRESENCE_WAIT: timing.presence_wait_limit = val[9:0];
            owbm_pkg::REG_SHORT_LOW:     timing.short_low_time = val[3:0];
            owbm_pkg::REG_LONG_SLOT:     timing.long_slot_time = val[6:0];
            owbm_pkg::REG_READ_SAMPLE:   timing.read_sample_delay = val[3:0];
            owbm_pkg::REG_READ_RECOVER:  timing.read_recover_time = val[7:0];
            default:                     ;
        endcase
    endtask

    task automatic set_timing(int rl, int rr, int pw, int sl, int ls, int rs, int rc);
        in_valid <= 1'b0;
        while (expected_ticks.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        write_timing(owbm_pkg::REG_RESET_LOW, cfg_word_t'(rl));
        write_timing(owbm_pkg::REG_RESET_RELEASE, cfg_word_t'(rr));
        write_timing(owbm_pkg::REG_PRESENCE_WAIT, cfg_word_t'(pw));
        write_timing(owbm_pkg::REG_SHORT_LOW, cfg_word_t'(sl));
        write_timing(owbm_pkg::REG_LONG_SLOT, cfg_word_t'(ls));
        write_timing(owbm_pkg::REG_READ_SAMPLE, cfg_word_t'(rs));
        write_timing(owbm_pkg::REG_READ_RECOVER, cfg_word_t'(rc));
        cfg_we <= 1'b0;
        timing_sets++;
    endtask

    task automatic test_default_timing();
        pres_low_after = 2;
        pres_high_after = 3;
        run_command(owbm_pkg::CMD_RESET, 8'h00);
    endtask

    task automatic test_zero_durations();
        set_timing(0, 0, 0, 0, 0, 0, 0);
        quiet_in = 1'b1;
        quiet_out = 1'b1;
        pres_low_after = 5000;
        run_command(owbm_pkg::CMD_RESET, 8'hFF);
        pres_low_after = 0;
        pres_high_after = 0;
        run_command(owbm_pkg::CMD_RESET, 8'h00);
        run_command(owbm_pkg::CMD_WRITE, 8'h00);
        run_command(owbm_pkg::CMD_WRITE, 8'hFF);
        run_command(owbm_pkg::CMD_READ, 8'h00);
        quiet_in = 1'b0;
        quiet_out = 1'b0;
    endtask

    task automatic test_timing_extremes();
        set_timing(0, 0, 1, 1, 15, 1, 0);
        pres_low_after = 0;
        pres_high_after = 0;
        run_command(owbm_pkg::CMD_RESET, 8'h11);
        run_command(owbm_pkg::CMD_WRITE, 8'h5A);
        run_command(owbm_pkg::CMD_READ, 8'hC3);
        set_timing(1023, 1, 1023, 15, 120, 15, 255);
        pres_low_after = 0;
        pres_high_after = 0;
        run_command(owbm_pkg::CMD_RESET, 8'h7E);
    endtask

    task automatic test_presence_edges();
        int low_at[5] = '{0, 5, 6, 0, 2};
        int high_at[5] = '{0, 5, 0, 6, 3};
        set_timing(4, 2, 6, 1, 15, 1, 1);
        for (int i = 0; i < 5; i++)
        begin
            pres_low_after = low_at[i];
            pres_high_after = high_at[i];
            run_command(owbm_pkg::CMD_RESET, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_random_traffic();
        while (beats_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 4) == 0)
                set_timing($urandom_range(0, 6), $urandom_range(0, 3), $urandom_range(0, 6),
                           ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                       : $urandom_range(0, 3),
                           ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20)
                                                       : $urandom_range(0, 6),
                           $urandom_range(0, 6), $urandom_range(0, 4));
            quiet_in = ($urandom_range(0, 3) == 0);
            quiet_out = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(0, 3))
                send_beat(owbm_pkg::CMD_TICK, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            pres_low_after = $urandom_range(0, 7);
            pres_high_after = $urandom_range(0, 7);
            run_command(owbm_pkg::cmd_t'($urandom_range(1, 3)), 8'($urandom_range(0, 255)));
        end
        quiet_in = 1'b0;
        quiet_out = 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_ticks.size() == 0)
                report_mismatch("output beat with nothing expected");
            else
            begin
                want = expected_ticks.pop_front();
                check_field("drive_low", drive_low, want.drive_low);
                check_field("busy_res", busy_res, want.busy_res);
                check_field("done_res", done_res, want.done_res);
                check_field("status", status, want.status);
                check_field("rx_byte", rx_byte, want.rx_byte);
            end
        end
    end

    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            hold = quiet_out ? 0 : $urandom_range(0, 19);
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        #(25_000_000);
        $display("Timeout with %0d output beats outstanding.", expected_ticks.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        timing = {owbm_pkg::RESET_LOW_INIT, owbm_pkg::RESET_RELEASE_INIT,
                  owbm_pkg::PRESENCE_WAIT_INIT, owbm_pkg::SHORT_LOW_INIT,
                  owbm_pkg::LONG_SLOT_INIT, owbm_pkg::READ_SAMPLE_INIT,
                  owbm_pkg::READ_RECOVER_INIT};
        seq = SEQ_IDLE;
        tcount = 0;
        bit_pos = 0;
        shift_reg = 8'h00;
        no_presence = 1'b0;
        last_read = 8'h00;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_timing();
        test_zero_durations();
        test_timing_extremes();
        test_presence_edges();
        test_random_traffic();

        in_valid <= 1'b0;
        while (expected_ticks.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        $display("Sent %0d beats under %0d timing sets: %0d resets, %0d writes, %0d reads.",
                 beats_sent, timing_sets, resets_run, writes_run, reads_run);
        $display("Presence seen %0d times and missed %0d times; %0d mismatches.",
                 devices_found, devices_missed, mismatch_count);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== one_wire_bus_master_unit.f =====
hw/rtl/owbm_pkg.sv
hw/rtl/owbm_cfg.sv
hw/rtl/owbm_step.sv
hw/rtl/one_wire_bus_master_unit.sv
sim/tb.sv
